// ----- hdl/cga_pkg.sv -----
// Shared constants for the CGA text port register block.
package cga_pkg;

   localparam int unsigned OP_W = 2;
   localparam int unsigned SEL_W = 3;
   localparam int unsigned BYTE_W = 8;
   localparam int unsigned TICKS_W = 32;
   localparam int unsigned TIMING_W = 16;
   localparam int unsigned PHASE_W = 18;
   localparam int unsigned GEN_W = 32;
   localparam int unsigned CSR_IDX_W = 2;
   localparam int unsigned CRTC_DEPTH = 6;
   localparam int unsigned CRTC_IDX_W = 3;
   localparam int unsigned DIV_W = TICKS_W + 1;
   localparam int unsigned CNT_W = 6;

   typedef enum logic [OP_W-1:0] {
      OP_READ    = 2'd0,
      OP_WRITE   = 2'd1,
      OP_ADVANCE = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   localparam logic [SEL_W-1:0] PORT_INDEX  = 3'd0;
   localparam logic [SEL_W-1:0] PORT_DATA   = 3'd1;
   localparam logic [SEL_W-1:0] PORT_MODE   = 3'd2;
   localparam logic [SEL_W-1:0] PORT_COLOR  = 3'd3;
   localparam logic [SEL_W-1:0] PORT_STATUS = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HBLANK  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RETRACE = 2'd2;

   localparam logic [BYTE_W-1:0] CRTC_FIRST     = 8'h0a;
   localparam logic [BYTE_W-1:0] CRTC_LAST      = 8'h0f;
   localparam logic [BYTE_W-1:0] MODE_WIDE      = 8'h01;
   localparam logic [BYTE_W-1:0] MODE_GRAPHICS  = 8'h02;
   localparam logic [BYTE_W-1:0] MODE_COLOR     = 8'h04;
   localparam logic [BYTE_W-1:0] STATUS_DISPLAY = 8'h01;
   localparam logic [BYTE_W-1:0] STATUS_RETRACE = 8'h08;

   localparam logic [TIMING_W-1:0] ACTIVE_RESET  = 16'd48;
   localparam logic [TIMING_W-1:0] HBLANK_RESET  = 16'd8;
   localparam logic [TIMING_W-1:0] RETRACE_RESET = 16'd8;
   localparam logic [BYTE_W-1:0]   MODE_RESET    = 8'h05;
   localparam logic [BYTE_W-1:0]   CURSOR_START_RESET = 8'd6;
   localparam logic [BYTE_W-1:0]   CURSOR_END_RESET   = 8'd7;
   localparam logic [GEN_W-1:0]    GEN_RESET     = 32'd1;

endpackage

// ----- hdl/cga_text_port_registers_core.sv -----
// Top level of the CGA text port register block with an iterative modulo unit.
// Port reads and writes register their result on acceptance, one per cycle while the response
// output is free and no advance is running. A time advance runs 33 steps of the restoring
// remainder unit that reduce the 33-bit sum of phase and elapsed ticks by the raster period,
// then a write-back state; no new transaction is accepted until its result is registered.
// Synchronous active-high reset restores all port, timing and change-counter state.
module cga_text_port_registers_core
   import cga_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [39:0]          req_tdata,  // write_data, tick_count
   input  logic [4:0]           req_tuser,  // operation, port_select
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [47:0]          rsp_tdata,  // read_data, wide_columns, color_on, change_count
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TIMING_W-1:0]  csr_wdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   localparam int unsigned RSP_W = BYTE_W + 2 + GEN_W;

   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]       rsp_data_ff, rsp_data_in;
   logic [TIMING_W-1:0]    active_ff, active_in;
   logic [TIMING_W-1:0]    hblank_ff, hblank_in;
   logic [TIMING_W-1:0]    retrace_ff, retrace_in;
   logic [BYTE_W-1:0]      crtc_file_ff [CRTC_DEPTH];
   logic [BYTE_W-1:0]      crtc_file_in [CRTC_DEPTH];
   logic [BYTE_W-1:0]      pointer_ff, pointer_in;
   logic [BYTE_W-1:0]      mode_ff, mode_in;
   logic [BYTE_W-1:0]      color_ff, color_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [GEN_W-1:0]       gen_ff, gen_in;
   logic [DIV_W-1:0]       dividend_ff, dividend_in;
   logic [PHASE_W-1:0]     rem_ff, rem_in;
   logic [PHASE_W-1:0]     period_ff, period_in;
   logic [CNT_W-1:0]       count_ff, count_in;

   logic                   out_free;
   logic                   accept;
   op_type                 req_op;
   logic [SEL_W-1:0]       req_sel;
   logic [BYTE_W-1:0]      req_byte;
   logic [TICKS_W-1:0]     req_ticks;
   logic                   crtc_hit;
   logic [BYTE_W-1:0]      crtc_offset;
   logic [CRTC_IDX_W-1:0]  crtc_sel;
   logic [BYTE_W-1:0]      status_val;
   logic [PHASE_W-1:0]     enable_limit;
   logic [PHASE_W:0]       trial;
   logic                   trial_ge;
   logic [BYTE_W-1:0]      rd_val;
   logic                   load_rsp;

   assign out_free    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = (state_ff == ST_IDLE) && out_free;
   assign accept      = req_tvalid && req_tready;
   assign req_op      = op_type'(req_tuser[OP_W-1:0]);
   assign req_sel     = req_tuser[OP_W +: SEL_W];
   assign req_byte    = req_tdata[BYTE_W-1:0];
   assign req_ticks   = req_tdata[BYTE_W +: TICKS_W];

   assign crtc_hit    = (pointer_ff >= CRTC_FIRST) && (pointer_ff <= CRTC_LAST);
   assign crtc_offset = pointer_ff - CRTC_FIRST;
   assign crtc_sel    = crtc_offset[CRTC_IDX_W-1:0];

   assign enable_limit = PHASE_W'(retrace_ff) + PHASE_W'(active_ff);
   assign status_val  = (phase_ff < PHASE_W'(retrace_ff)) ? STATUS_RETRACE :
                        (phase_ff < enable_limit) ? STATUS_DISPLAY : '0;

   assign trial       = {rem_ff, dividend_ff[DIV_W-1]};
   assign trial_ge    = trial >= {1'b0, period_ff};

   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = {{(48 - RSP_W){1'b0}}, rsp_data_ff};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      active_in    = active_ff;
      hblank_in    = hblank_ff;
      retrace_in   = retrace_ff;
      crtc_file_in = crtc_file_ff;
      pointer_in   = pointer_ff;
      mode_in      = mode_ff;
      color_in     = color_ff;
      phase_in     = phase_ff;
      gen_in       = gen_ff;
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      period_in    = period_ff;
      count_in     = count_ff;
      rd_val       = '0;
      load_rsp     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               load_rsp = 1'b1;
               unique case (req_op)
                  OP_READ: begin
                     case (req_sel)
                        PORT_INDEX:  rd_val = pointer_ff;
                        PORT_DATA:   rd_val = crtc_hit ? crtc_file_ff[crtc_sel] : '0;
                        PORT_MODE:   rd_val = mode_ff;
                        PORT_COLOR:  rd_val = color_ff;
                        PORT_STATUS: rd_val = status_val;
                        default:     rd_val = '0;
                     endcase
                  end
                  OP_WRITE: begin
                     case (req_sel)
                        PORT_INDEX: pointer_in = req_byte;
                        PORT_DATA: begin
                           if (crtc_hit && (crtc_file_ff[crtc_sel] != req_byte)) begin
                              crtc_file_in[crtc_sel] = req_byte;
                              gen_in = gen_ff + 1'b1;
                           end
                        end
                        PORT_MODE: begin
                           if (((req_byte & MODE_GRAPHICS) == '0) && (mode_ff != req_byte)) begin
                              mode_in = req_byte;
                              gen_in = gen_ff + 1'b1;
                           end
                        end
                        PORT_COLOR: begin
                           if (color_ff != req_byte) begin
                              color_in = req_byte;
                              gen_in = gen_ff + 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
                  OP_ADVANCE: begin
                     load_rsp    = 1'b0;
                     dividend_in = {1'b0, req_ticks} + DIV_W'(phase_ff);
                     rem_in      = '0;
                     period_in   = PHASE_W'(active_ff) + PHASE_W'(hblank_ff)
                                   + PHASE_W'(retrace_ff);
                     count_in    = CNT_W'(DIV_W - 1);
                     state_in    = ST_DIVIDE;
                  end
                  default: ;
               endcase
            end
         end
         ST_DIVIDE: begin
            rem_in      = trial_ge ? PHASE_W'(trial - {1'b0, period_ff})
                                   : trial[PHASE_W-1:0];
            dividend_in = {dividend_ff[DIV_W-2:0], 1'b0};
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               phase_in = rem_ff;
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {gen_in, (mode_in & MODE_COLOR) != '0,
                         (mode_in & MODE_WIDE) != '0, rd_val};
      end

      if (csr_we) begin
         unique case (csr_index)
            CSR_ACTIVE: begin
               if (csr_wdata != '0) active_in = csr_wdata;
            end
            CSR_HBLANK: hblank_in = csr_wdata;
            CSR_RETRACE: begin
               if (csr_wdata != '0) begin
                  retrace_in = csr_wdata;
                  phase_in   = PHASE_W'(csr_wdata);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         active_ff    <= ACTIVE_RESET;
         hblank_ff    <= HBLANK_RESET;
         retrace_ff   <= RETRACE_RESET;
         for (int i = 0; i < CRTC_DEPTH; i++) begin
            crtc_file_ff[i] <= (i == 0) ? CURSOR_START_RESET :
                               (i == 1) ? CURSOR_END_RESET : '0;
         end
         pointer_ff   <= '0;
         mode_ff      <= MODE_RESET;
         color_ff     <= '0;
         phase_ff     <= PHASE_W'(RETRACE_RESET);
         gen_ff       <= GEN_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         hblank_ff    <= hblank_in;
         retrace_ff   <= retrace_in;
         crtc_file_ff <= crtc_file_in;
         pointer_ff   <= pointer_in;
         mode_ff      <= mode_in;
         color_ff     <= color_in;
         phase_ff     <= phase_in;
         gen_ff       <= gen_in;
      end
      rsp_data_ff <= rsp_data_in;
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      period_ff   <= period_in;
      count_ff    <= count_in;
   end

`ifndef SYNTHESIS
   a_advance_starts_divide: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_ADVANCE)) |=> (state_ff == ST_DIVIDE))
      else $error("Advance transaction did not start the remainder unit.");

   a_remainder_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (rem_ff < period_ff))
      else $error("Remainder is not below the raster period.");

   a_divide_keeps_generation: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |=> $stable(gen_ff))
      else $error("Generation changed during an advance.");
`endif

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the CGA text port register block.
`timescale 1ns / 1ps

module testbench;
   import cga_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int unsigned PHASE_COUNT = 6;
   localparam int unsigned BATCH_ITEMS = 162;

   typedef struct {
      op_type           op;
      logic [SEL_W-1:0] port;
      logic [BYTE_W-1:0] wdata;
      logic [TICKS_W-1:0] ticks;
   } port_access_type;

   typedef struct {
      logic [BYTE_W-1:0] read_data;
      logic              wide;
      logic              color;
      logic [GEN_W-1:0]  gen;
   } port_reply_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [39:0]          req_tdata = '0;  // write_data, tick_count
   logic [4:0]           req_tuser = '0;  // operation, port_select
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [47:0]          rsp_tdata;       // read_data, wide_columns, color_on, change_count
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [TIMING_W-1:0]  csr_wdata = '0;

   // Predicted block state.
   logic [TIMING_W-1:0] active_ticks;
   logic [TIMING_W-1:0] hblank_ticks;
   logic [TIMING_W-1:0] retrace_ticks;
   logic [BYTE_W-1:0]   crtc_regs [CRTC_DEPTH];
   logic [BYTE_W-1:0]   crtc_pointer;
   logic [BYTE_W-1:0]   mode_byte;
   logic [BYTE_W-1:0]   color_byte;
   logic [PHASE_W-1:0]  phase_model;
   logic [GEN_W-1:0]    generation;

   port_access_type pending_accesses [$];
   port_reply_type  predicted_replies [$];
   port_access_type on_wire;
   port_reply_type  oldest_reply;
   int unsigned  send_idle_pct = 10;
   int unsigned  recv_idle_pct = 84;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count = 0;

   cga_text_port_registers_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic void update_byte(inout logic [BYTE_W-1:0] slot,
                                       input logic [BYTE_W-1:0] value);
      if (slot != value) begin
         slot = value;
         generation = generation + 1'b1;
      end
   endfunction

   function automatic port_reply_type predict_port_access(port_access_type a);
      port_reply_type r;
      logic [63:0] span;
      logic        crtc_hit;
      int          slot;
      span = 64'(active_ticks) + 64'(hblank_ticks) + 64'(retrace_ticks);
      crtc_hit = (crtc_pointer >= CRTC_FIRST) && (crtc_pointer <= CRTC_LAST);
      slot = int'(crtc_pointer - CRTC_FIRST);
      r.read_data = '0;
      case (a.op)
         OP_READ: begin
            case (a.port)
               PORT_INDEX: r.read_data = crtc_pointer;
               PORT_DATA: if (crtc_hit) r.read_data = crtc_regs[slot];
               PORT_MODE: r.read_data = mode_byte;
               PORT_COLOR: r.read_data = color_byte;
               PORT_STATUS: begin
                  if (32'(phase_model) < 32'(retrace_ticks))
                     r.read_data = STATUS_RETRACE;
                  else if (32'(phase_model) < 32'(retrace_ticks) + 32'(active_ticks))
                     r.read_data = STATUS_DISPLAY;
               end
               default: r.read_data = '0;
            endcase
         end
         OP_WRITE: begin
            case (a.port)
               PORT_INDEX: crtc_pointer = a.wdata;
               PORT_DATA: if (crtc_hit) update_byte(crtc_regs[slot], a.wdata);
               PORT_MODE: if ((a.wdata & MODE_GRAPHICS) == '0) update_byte(mode_byte, a.wdata);
               PORT_COLOR: update_byte(color_byte, a.wdata);
               default: ;
            endcase
         end
         OP_ADVANCE: phase_model = PHASE_W'((64'(phase_model) + 64'(a.ticks) % span) % span);
         default: ;
      endcase
      r.wide = (mode_byte & MODE_WIDE) != '0;
      r.color = (mode_byte & MODE_COLOR) != '0;
      r.gen = generation;
      return r;
   endfunction

   function automatic port_access_type make_access(op_type op, logic [SEL_W-1:0] port,
                                                   logic [BYTE_W-1:0] wdata,
                                                   logic [TICKS_W-1:0] ticks);
      port_access_type a;
      a.op = op;
      a.port = port;
      a.wdata = wdata;
      a.ticks = ticks;
      return a;
   endfunction

   // Mostly well-formed register traffic, with a share of noise on top.
   function automatic port_access_type random_access();
      port_access_type a;
      int unsigned  pick;
      a = make_access(OP_READ, PORT_STATUS, BYTE_W'($urandom), $urandom);
      pick = $urandom_range(99);
      if ($urandom_range(9) < 3) a.wdata = BYTE_W'($urandom_range(3));
      if (pick < 25) begin
         a.op = OP_ADVANCE;
         case ($urandom_range(4))
            0: a.ticks = $urandom_range(40);
            1: a.ticks = $urandom_range(3 * 65535);
            2: a.ticks = $urandom_range(1) ? '1 : '0;
            default: a.ticks = $urandom;
         endcase
      end else if (pick < 45) begin
         a.op = OP_READ;
      end else if (pick < 60) begin
         a.op = OP_WRITE;
         a.port = PORT_INDEX;
         if ($urandom_range(3) != 0) a.wdata = BYTE_W'($urandom_range(CRTC_LAST, CRTC_FIRST));
      end else if (pick < 75) begin
         a.op = $urandom_range(1) ? OP_WRITE : OP_READ;
         a.port = PORT_DATA;
      end else if (pick < 85) begin
         a.op = $urandom_range(1) ? OP_WRITE : OP_READ;
         a.port = PORT_MODE;
      end else if (pick < 93) begin
         a.op = $urandom_range(1) ? OP_WRITE : OP_READ;
         a.port = PORT_COLOR;
      end else begin
         a.op = op_type'($urandom_range(3));
         a.port = SEL_W'($urandom_range(7));
      end
      return a;
   endfunction

   task automatic queue_random(int unsigned count);
      repeat (count) pending_accesses.push_back(random_access());
   endtask

   task automatic wait_drained();
      while (pending_accesses.size() != 0 || req_tvalid || predicted_replies.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_timing(logic [CSR_IDX_W-1:0] idx, logic [TIMING_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ACTIVE: if (value != '0) active_ticks = value;
         CSR_HBLANK: hblank_ticks = value;
         CSR_RETRACE: begin
            if (value != '0) begin
               retrace_ticks = value;
               phase_model = PHASE_W'(value);
            end
         end
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic report_mismatch(string field, logic [GEN_W-1:0] got, logic [GEN_W-1:0] want);
      mismatch_count++;
      $display("%0t: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predicted_replies.push_back(predict_port_access(on_wire));
         if (!req_tvalid || req_tready) begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_wire = pending_accesses.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {on_wire.ticks, on_wire.wdata};
               req_tuser <= {on_wire.port, on_wire.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (predicted_replies.size() == 0) begin
               report_mismatch("unexpected transaction", GEN_W'(rsp_tdata), '0);
            end else begin
               oldest_reply = predicted_replies.pop_front();
               if (rsp_tdata[7:0] !== oldest_reply.read_data)
                  report_mismatch("read_data", GEN_W'(rsp_tdata[7:0]),
                                  GEN_W'(oldest_reply.read_data));
               if (rsp_tdata[8] !== oldest_reply.wide)
                  report_mismatch("wide_columns", GEN_W'(rsp_tdata[8]),
                                  GEN_W'(oldest_reply.wide));
               if (rsp_tdata[9] !== oldest_reply.color)
                  report_mismatch("color_on", GEN_W'(rsp_tdata[9]),
                                  GEN_W'(oldest_reply.color));
               if (rsp_tdata[41:10] !== oldest_reply.gen)
                  report_mismatch("change_count", rsp_tdata[41:10], oldest_reply.gen);
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      active_ticks = ACTIVE_RESET;
      hblank_ticks = HBLANK_RESET;
      retrace_ticks = RETRACE_RESET;
      foreach (crtc_regs[i]) crtc_regs[i] = '0;
      crtc_regs[0] = CURSOR_START_RESET;
      crtc_regs[1] = CURSOR_END_RESET;
      crtc_pointer = '0;
      mode_byte = MODE_RESET;
      color_byte = '0;
      phase_model = PHASE_W'(RETRACE_RESET);
      generation = GEN_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed accesses under the reset timing.
      pending_accesses.push_back(make_access(OP_READ, PORT_STATUS, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_INDEX, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_DATA, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_DATA, 8'h33, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_INDEX, CRTC_FIRST, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_DATA, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_DATA, CURSOR_START_RESET, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_DATA, 8'hff, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_INDEX, CRTC_LAST, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_DATA, 8'h80, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_DATA, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_INDEX, 8'hff, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_DATA, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_MODE, 8'hff, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_MODE, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_MODE, MODE_RESET, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_COLOR, 8'hff, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_COLOR, 8'hff, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_COLOR, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_STATUS, 8'h55, '0));
      pending_accesses.push_back(make_access(OP_WRITE, PORT_STATUS + 3'd3, 8'haa, '0));
      pending_accesses.push_back(make_access(OP_READ, PORT_STATUS + 3'd1, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_NONE, PORT_DATA, 8'hff, '1));
      pending_accesses.push_back(make_access(OP_ADVANCE, PORT_INDEX, 8'h00, '0));
      pending_accesses.push_back(make_access(OP_ADVANCE, PORT_INDEX, 8'h00, '1));
      pending_accesses.push_back(make_access(OP_READ, PORT_STATUS, 8'h00, '0));
      wait_drained();

      for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 10; recv_idle_pct = 84; end
            1: begin send_idle_pct = 84; recv_idle_pct = 10; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            1: begin
               write_timing(CSR_ACTIVE, 16'd1);
               write_timing(CSR_HBLANK, 16'd0);
               write_timing(CSR_RETRACE, 16'd1);
            end
            2: begin
               write_timing(CSR_ACTIVE, '1);
               write_timing(CSR_HBLANK, '1);
               write_timing(CSR_RETRACE, '1);
            end
            3: begin
               // Zero active and retrace writes are dropped; the shrink can leave the phase past the period.
               write_timing(CSR_ACTIVE, 16'd0);
               write_timing(CSR_RETRACE, 16'd0);
               write_timing(CSR_ACTIVE, 16'd5);
               write_timing(CSR_HBLANK, 16'd0);
            end
            4: begin
               write_timing(CSR_ACTIVE, TIMING_W'($urandom_range(65535, 1)));
               write_timing(CSR_HBLANK, TIMING_W'($urandom_range(65535)));
               write_timing(CSR_RETRACE, TIMING_W'($urandom_range(65535, 1)));
            end
            5: begin
               write_timing(CSR_ACTIVE, TIMING_W'($urandom_range(100, 1)));
               write_timing(CSR_HBLANK, TIMING_W'($urandom_range(50)));
               write_timing(CSR_RETRACE, TIMING_W'($urandom_range(60, 1)));
            end
            default: ;
         endcase
         @(negedge clock);
         queue_random(BATCH_ITEMS);
         wait_drained();
         queue_random(BATCH_ITEMS);
         wait_drained();
      end

      repeat (50) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/cga_pkg.sv
hdl/cga_text_port_registers_core.sv
bench/testbench.sv
